// ----- hdl/e2q_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_pkg
// Types, constants and helpers for the Euler angle to quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int AngleWidth  = 16;
  localparam int ResultWidth = 16;
  localparam int CordicSteps = 24;
  // CORDIC datapath width: Q.30 values stay well inside 34 bits
  localparam int CW          = 34;

  localparam logic signed [CW-1:0] PiQ29    = 34'sd1686629713;
  localparam logic signed [CW-1:0] TwoPiQ29 = 34'sd3373259426;
  localparam logic signed [CW-1:0] GainQ30  = 34'sd652032874;

  typedef logic signed [CW-1:0] cval_t;

  typedef struct packed {
    logic signed [AngleWidth-1:0] roll_angle;
    logic signed [AngleWidth-1:0] pitch_angle;
    logic signed [AngleWidth-1:0] yaw_angle;
  } e2q_in_t;

  typedef struct packed {
    logic signed [ResultWidth-1:0] quat_w;
    logic signed [ResultWidth-1:0] quat_x;
    logic signed [ResultWidth-1:0] quat_y;
    logic signed [ResultWidth-1:0] quat_z;
  } e2q_out_t;

  // Rotation state for one angle
  typedef struct packed {
    cval_t x;
    cval_t y;
    cval_t z;
  } rot_t;

  function automatic cval_t atan_q30(input int i);
    case (i)
      0:  atan_q30 = 34'sd843314856;
      1:  atan_q30 = 34'sd497837829;
      2:  atan_q30 = 34'sd263043836;
      3:  atan_q30 = 34'sd133525158;
      4:  atan_q30 = 34'sd67021686;
      5:  atan_q30 = 34'sd33543515;
      6:  atan_q30 = 34'sd16775850;
      7:  atan_q30 = 34'sd8388437;
      8:  atan_q30 = 34'sd4194282;
      9:  atan_q30 = 34'sd2097149;
      default: atan_q30 = cval_t'(34'sd1) <<< (30 - i);
    endcase
  endfunction

  // Wrap a Q3 angle into [-pi, pi] as Q.29 (read later as Q.30 half angle)
  function automatic cval_t wrap_angle(input logic signed [AngleWidth-1:0] a);
    cval_t v;
    v = cval_t'(a) <<< (32 - AngleWidth);
    if (v > PiQ29) wrap_angle = v - TwoPiQ29;
    else if (v < -PiQ29) wrap_angle = v + TwoPiQ29;
    else wrap_angle = v;
  endfunction

  // One CORDIC rotation step
  function automatic rot_t cordic_step(input rot_t r, input int i);
    rot_t o;
    o = r;
    if (!r.z[CW-1]) begin
      o.x = r.x - (r.y >>> i);
      o.y = r.y + (r.x >>> i);
      o.z = r.z - atan_q30(i);
    end else begin
      o.x = r.x + (r.y >>> i);
      o.y = r.y - (r.x >>> i);
      o.z = r.z + atan_q30(i);
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/euler_to_quaternion_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit
// Roll, pitch and yaw (Q3.13 rad) to unit quaternion w, x, y, z (Q1.15).
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted every cycle while the output
// is not stalled. One wrap stage, eight CORDIC stages of three rotations
// each (all three angles in parallel), one stage of pair products, one
// stage of triple products and one sum stage feed the output register,
// which rounds and saturates; the CORDIC chain sets the depth. A stall
// at the output freezes the whole pipeline. No state survives a transaction.
module euler_to_quaternion_unit
  import e2q_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire e2q_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output e2q_out_t      out_data
);

  localparam int CStages = CordicSteps / 3;
  localparam int NStages = CStages + 5;
  localparam int Sh      = 61 - ResultWidth;
  localparam int PW      = 2 * CW;
  localparam int TW      = 100;

  logic [NStages-1:0] vld_r;
  logic               adv;

  // Advance everything when the output slot is free or being taken
  assign adv       = !vld_r[NStages-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[NStages-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NStages-2:0], in_valid};
    end
  end

  // Stage 0: wrap angles and load rotators
  rot_t rot_r [CStages+1][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      rot_r[0][0] <= '{x: GainQ30, y: '0, z: wrap_angle(in_data.roll_angle)};
      rot_r[0][1] <= '{x: GainQ30, y: '0, z: wrap_angle(in_data.pitch_angle)};
      rot_r[0][2] <= '{x: GainQ30, y: '0, z: wrap_angle(in_data.yaw_angle)};
    end
  end

  // CORDIC stages, three rotations per stage
  for (genvar s = 0; s < CStages; s++) begin : g_cordic
    for (genvar a = 0; a < 3; a++) begin : g_axis
      rot_t r1, r2, r3;
      always_comb begin
        r1 = cordic_step(rot_r[s][a], 3 * s);
        r2 = cordic_step(r1, 3 * s + 1);
        r3 = cordic_step(r2, 3 * s + 2);
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          rot_r[s+1][a] <= r3;
        end
      end
    end
  end

  cval_t cr, sr, cp, sp, cy, sy;
  assign cr = rot_r[CStages][0].x;
  assign sr = rot_r[CStages][0].y;
  assign cp = rot_r[CStages][1].x;
  assign sp = rot_r[CStages][1].y;
  assign cy = rot_r[CStages][2].x;
  assign sy = rot_r[CStages][2].y;

  // Pair products of pitch and yaw terms, rounded to Q.30
  function automatic cval_t mul_q30(input cval_t a, input cval_t b);
    logic signed [PW-1:0] p;
    p = (PW'(a) * PW'(b)) + (PW'(1) <<< 29);
    return CW'(p >>> 30);
  endfunction

  cval_t cpcy_r, spsy_r, spcy_r, cpsy_r, cr_r, sr_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      cpcy_r <= mul_q30(cp, cy);
      spsy_r <= mul_q30(sp, sy);
      spcy_r <= mul_q30(sp, cy);
      cpsy_r <= mul_q30(cp, sy);
      cr_r   <= cr;
      sr_r   <= sr;
    end
  end

  // Triple products in Q.60
  logic signed [PW-1:0] t_r [8];
  always_ff @(posedge clk) begin
    if (adv) begin
      t_r[0] <= PW'(cr_r) * PW'(cpcy_r);
      t_r[1] <= PW'(sr_r) * PW'(spsy_r);
      t_r[2] <= PW'(sr_r) * PW'(cpcy_r);
      t_r[3] <= PW'(cr_r) * PW'(spsy_r);
      t_r[4] <= PW'(cr_r) * PW'(spcy_r);
      t_r[5] <= PW'(sr_r) * PW'(cpsy_r);
      t_r[6] <= PW'(cr_r) * PW'(cpsy_r);
      t_r[7] <= PW'(sr_r) * PW'(spcy_r);
    end
  end

  // Combine terms
  logic signed [PW:0] v_r [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      v_r[0] <= (PW+1)'(t_r[0]) + (PW+1)'(t_r[1]);
      v_r[1] <= (PW+1)'(t_r[2]) - (PW+1)'(t_r[3]);
      v_r[2] <= (PW+1)'(t_r[4]) + (PW+1)'(t_r[5]);
      v_r[3] <= (PW+1)'(t_r[6]) - (PW+1)'(t_r[7]);
    end
  end

  // Round half up and saturate
  function automatic logic signed [ResultWidth-1:0] finish(
      input logic signed [PW:0] v);
    logic signed [PW:0] r;
    r = (v + ((PW+1)'(1) <<< (Sh - 1))) >>> Sh;
    if (r > (PW+1)'((64'sd1 <<< (ResultWidth - 1)) - 1))
      finish = {1'b0, {(ResultWidth-1){1'b1}}};
    else if (r < -(PW+1)'(64'sd1 <<< (ResultWidth - 1)))
      finish = {1'b1, {(ResultWidth-1){1'b0}}};
    else
      finish = r[ResultWidth-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.quat_w <= finish(v_r[0]);
      out_data.quat_x <= finish(v_r[1]);
      out_data.quat_y <= finish(v_r[2]);
      out_data.quat_z <= finish(v_r[3]);
    end
  end

endmodule

`default_nettype wire
